### rtl/erma_pkg.sv
package erma_pkg;

    localparam int ECHO_W  = 15;
    localparam int SCALE_W = 16;
    localparam int DIST_W  = 17;
    localparam int PROD_W  = ECHO_W + SCALE_W;
    localparam int FRAC_SHIFT = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    typedef logic [ECHO_W-1:0]     echo_t;
    typedef logic [SCALE_W-1:0]    scale_t;
    typedef logic [DIST_W-1:0]     dist_t;
    typedef logic [PROD_W-1:0]     prod_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t REG_SCALE_FACTOR   = 2'd0;
    localparam cfg_idx_t REG_SEND_THRESHOLD = 2'd1;

    localparam scale_t SCALE_RESET  = 16'd1124;
    localparam dist_t  THRESH_RESET = 17'd7680;
    localparam dist_t  DIST_MAX     = 17'h1FFFF;

endpackage

### rtl/echo_range_moving_average_top.sv
// Ultrasonic range filter with a moving average over the last WINDOW echoes.
// Input channel (s_*): one echo time in microseconds plus the link state per
// transfer; an echo time of zero marks a timeout and stores nothing.
// Result channel (m_*): one result per input transfer, in order, holding the
// converted distance, the mean of the stored samples and the send flag.
// Configuration channel (cfg_*): index 0 writes scale_factor, index 1 writes
// send_threshold; other indexes are dropped. cfg_ready is always high.
// One shared multiplier, one adder and a one-bit-per-cycle restoring divider
// run under a small sequencer, so s_ready is low while an item is in work.
// An item passes through the conversion (multiply, then saturate and store),
// the sum over the stored samples, a divide of SUM_W quotient bits (20 at
// WINDOW = 5) and the load of the output register; the next input is taken
// only once the sequencer is back in idle. A timeout on an empty ring skips
// the sum and the divide.
// The result waits in the output register while m_ready is low; the next
// input is still taken, and its result waits until the slot is free.
// Reset empties the ring, returns both registers to their defaults and
// drops m_valid.
module echo_range_moving_average_top #(
    parameter int WINDOW = 5
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  erma_pkg::cfg_idx_t        cfg_index,
    input  erma_pkg::cfg_data_t       cfg_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  erma_pkg::echo_t           s_echo_time_us,
    input  logic                      s_link_connected,

    output logic                      m_valid,
    input  logic                      m_ready,
    output erma_pkg::dist_t           m_raw_distance,
    output logic                      m_raw_valid,
    output erma_pkg::dist_t           m_average_distance,
    output logic                      m_average_valid,
    output logic                      m_send_now
);

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = erma_pkg::DIST_W + CNT_W;
    localparam int BIT_W  = $clog2(SUM_W);
    localparam int DW     = erma_pkg::DIST_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]            state_reg;
    erma_pkg::scale_t      scale_reg;
    erma_pkg::dist_t       thresh_reg;
    erma_pkg::echo_t       echo_reg;
    logic                  link_reg;
    erma_pkg::prod_t       prod_reg;
    erma_pkg::dist_t       raw_reg;
    logic                  raw_ok_reg;
    erma_pkg::dist_t       ring_reg [WINDOW];
    logic [SLOT_W-1:0]     slot_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic [SLOT_W-1:0]     idx_reg;
    logic [SUM_W-1:0]      acc_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [BIT_W-1:0]      bit_reg;

    logic                  m_valid_reg;
    erma_pkg::dist_t       m_raw_reg;
    logic                  m_raw_ok_reg;
    erma_pkg::dist_t       m_avg_reg;
    logic                  m_avg_ok_reg;
    logic                  m_send_reg;

    erma_pkg::dist_t       raw_sat;
    logic [CNT_W-1:0]      fill_next;
    logic                  store_en;
    logic [SUM_W-1:0]      acc_add;
    logic                  sum_last;
    logic [CNT_W:0]        rem_shift;
    logic                  rem_ge;
    logic [CNT_W:0]        rem_sub;
    logic                  out_free;
    logic                  avg_ok;
    erma_pkg::dist_t       avg_val;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    // Saturate (echo * scale) >> 8 to the 17-bit distance range.
    always_comb begin
        if (|prod_reg[erma_pkg::PROD_W-1:erma_pkg::FRAC_SHIFT+DW]) begin
            raw_sat = erma_pkg::DIST_MAX;
        end else begin
            raw_sat = prod_reg[erma_pkg::FRAC_SHIFT+DW-1:erma_pkg::FRAC_SHIFT];
        end
    end

    assign store_en  = (echo_reg != '0);
    assign fill_next = (store_en && (fill_reg != CNT_W'(WINDOW))) ?
                       fill_reg + CNT_W'(1) : fill_reg;

    assign acc_add  = acc_reg + SUM_W'(ring_reg[idx_reg]);
    assign sum_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_reg);

    assign rem_shift = {rem_reg, acc_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, fill_reg});
    assign rem_sub   = rem_shift - {1'b0, fill_reg};

    assign avg_ok  = (fill_reg != '0);
    assign avg_val = avg_ok ? acc_reg[DW-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= erma_pkg::SCALE_RESET;
            thresh_reg <= erma_pkg::THRESH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                erma_pkg::REG_SCALE_FACTOR: begin
                    scale_reg <= cfg_data[erma_pkg::SCALE_W-1:0];
                end
                erma_pkg::REG_SEND_THRESHOLD: begin
                    thresh_reg <= cfg_data[DW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            fill_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        echo_reg  <= s_echo_time_us;
                        link_reg  <= s_link_connected;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= erma_pkg::prod_t'(echo_reg) * erma_pkg::prod_t'(scale_reg);
                    state_reg <= ST_STORE;
                end
                ST_STORE: begin
                    raw_ok_reg <= store_en;
                    raw_reg    <= store_en ? raw_sat : '0;
                    if (store_en) begin
                        ring_reg[slot_reg] <= raw_sat;
                        slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ?
                                    '0 : slot_reg + SLOT_W'(1);
                    end
                    fill_reg  <= fill_next;
                    acc_reg   <= '0;
                    idx_reg   <= '0;
                    state_reg <= (fill_next == '0) ? ST_OUT : ST_SUM;
                end
                ST_SUM: begin
                    acc_reg <= acc_add;
                    idx_reg <= idx_reg + SLOT_W'(1);
                    if (sum_last) begin
                        rem_reg   <= '0;
                        bit_reg   <= BIT_W'(SUM_W - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // Restoring divide: the quotient shifts in from the bottom
                    // as the dividend shifts out of the top.
                    rem_reg <= rem_ge ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                    acc_reg <= {acc_reg[SUM_W-2:0], rem_ge};
                    bit_reg <= bit_reg - BIT_W'(1);
                    if (bit_reg == '0) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_raw_reg    <= raw_reg;
            m_raw_ok_reg <= raw_ok_reg;
            m_avg_reg    <= avg_val;
            m_avg_ok_reg <= avg_ok;
            m_send_reg   <= avg_ok && link_reg && (avg_val < thresh_reg);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_raw_distance     = m_raw_reg;
    assign m_raw_valid        = m_raw_ok_reg;
    assign m_average_distance = m_avg_reg;
    assign m_average_valid    = m_avg_ok_reg;
    assign m_send_now         = m_send_reg;

endmodule

### sim/range_check_pkg.sv
`timescale 1ns / 100ps

package range_check_pkg;

    import erma_pkg::*;

    localparam int TRACK_WINDOW = 5;
    localparam int REPORT_LINES = 100;

    typedef struct packed {
        dist_t raw_distance;
        logic  raw_valid;
        dist_t average_distance;
        logic  average_valid;
        logic  send_now;
    } reading_t;

    class echo_average_tracker;

        scale_t   scale_word;
        dist_t    threshold;
        dist_t    samples [TRACK_WINDOW];
        int       next_slot;
        int       stored;
        reading_t pending_readings [$];
        int       readings_seen;
        int       errors;

        function new();
            scale_word    = SCALE_RESET;
            threshold     = THRESH_RESET;
            next_slot     = 0;
            stored        = 0;
            readings_seen = 0;
            errors        = 0;
        endfunction

        function void note_register(cfg_idx_t index, cfg_data_t value);
            case (index)
                REG_SCALE_FACTOR:   scale_word = value[SCALE_W-1:0];
                REG_SEND_THRESHOLD: threshold  = value[DIST_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out the reading one echo transfer produces and queues it.
        function void note_echo(echo_t echo, logic link);
            reading_t    want;
            logic [31:0] scaled;
            logic [31:0] total;
            want = '0;
            if (echo != '0) begin
                scaled = (32'(echo) * 32'(scale_word)) >> FRAC_SHIFT;
                want.raw_distance = (scaled > 32'(DIST_MAX)) ? DIST_MAX
                                                             : scaled[DIST_W-1:0];
                want.raw_valid = 1'b1;
                samples[next_slot] = want.raw_distance;
                next_slot = (next_slot == TRACK_WINDOW - 1) ? 0 : next_slot + 1;
                if (stored < TRACK_WINDOW) begin
                    stored++;
                end
            end
            if (stored > 0) begin
                total = '0;
                for (int i = 0; i < stored; i++) begin
                    total += 32'(samples[i]);
                end
                want.average_distance = DIST_W'(total / 32'(stored));
                want.average_valid    = 1'b1;
                want.send_now         = link && (want.average_distance < threshold);
            end
            pending_readings.push_back(want);
        endfunction

        function int pending_count();
            return pending_readings.size();
        endfunction

        task report(string what);
            if (errors < REPORT_LINES) begin
                $display("mismatch on reading %0d: %s", readings_seen, what);
            end
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report($sformatf("%s is %0d, expected %0d", name, got, want));
            end
        endtask

        task check_reading(reading_t got);
            reading_t want;
            if (pending_readings.size() == 0) begin
                report("result transfer with no reading expected");
            end else begin
                want = pending_readings.pop_front();
                compare_field("raw_distance", 32'(got.raw_distance),
                              32'(want.raw_distance));
                compare_field("raw_valid", 32'(got.raw_valid), 32'(want.raw_valid));
                compare_field("average_distance", 32'(got.average_distance),
                              32'(want.average_distance));
                compare_field("average_valid", 32'(got.average_valid),
                              32'(want.average_valid));
                compare_field("send_now", 32'(got.send_now), 32'(want.send_now));
            end
            readings_seen++;
        endtask

    endclass

endpackage

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import erma_pkg::*;
    import range_check_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 64;

    localparam cfg_idx_t REG_UNUSED_A = 2'd2;
    localparam cfg_idx_t REG_UNUSED_B = 2'd3;

    localparam echo_t ECHO_TIMEOUT   = 15'd0;
    localparam echo_t ECHO_MIN       = 15'd1;
    localparam echo_t ECHO_RANGE_MAX = 15'd30000;
    localparam echo_t ECHO_TOP_BIT   = 15'd16384;
    localparam echo_t ECHO_MAX       = 15'h7FFF;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;
    logic      s_valid;
    logic      s_ready;
    echo_t     s_echo_time_us;
    logic      s_link_connected;
    logic      m_valid;
    logic      m_ready;
    dist_t     m_raw_distance;
    logic      m_raw_valid;
    dist_t     m_average_distance;
    logic      m_average_valid;
    logic      m_send_now;

    echo_average_tracker tracker;
    bit idling_on   = 1'b1;
    bit hold_output = 1'b0;
    int cycle_count = 0;

    echo_range_moving_average_top #(
        .WINDOW(TRACK_WINDOW)
    ) i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_echo_time_us     (s_echo_time_us),
        .s_link_connected   (s_link_connected),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_raw_distance     (m_raw_distance),
        .m_raw_valid        (m_raw_valid),
        .m_average_distance (m_average_distance),
        .m_average_valid    (m_average_valid),
        .m_send_now         (m_send_now)
    );

    always #10 aclk = ~aclk;

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_echo(echo_t echo, logic link);
        int gap;
        gap = idling_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_echo_time_us   <= echo;
        s_link_connected <= link;
        do @(posedge aclk); while (!s_ready);
        tracker.note_echo(echo, link);
    endtask

    // Always waits on the clock before it returns, so a following transfer never
    // raises s_valid in the step where it was just lowered.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_count() != 0);
    endtask

    task automatic write_register(cfg_idx_t index, cfg_data_t value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.note_register(index, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(cfg_data_t scale_data, cfg_data_t threshold_data);
        wait_for_results();
        write_register(REG_SCALE_FACTOR, scale_data);
        write_register(REG_SEND_THRESHOLD, threshold_data);
        write_register($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
                       cfg_data_t'($urandom));
    endtask

    function automatic echo_t pick_echo();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            return ECHO_TIMEOUT;
        end else if (pick < 22) begin
            case ($urandom_range(0, 3))
                0:       return ECHO_MIN;
                1:       return ECHO_RANGE_MAX;
                2:       return ECHO_TOP_BIT;
                default: return ECHO_MAX;
            endcase
        end else if (pick < 35) begin
            return echo_t'($urandom_range(1, 32767));
        end
        return echo_t'($urandom_range(1, 30000));
    endfunction

    function automatic cfg_data_t pick_scale();
        int      pick;
        scale_t  scale_word;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            scale_word = '0;
        end else if (pick < 20) begin
            scale_word = '1;
        end else if (pick < 40) begin
            scale_word = SCALE_RESET;
        end else begin
            scale_word = scale_t'($urandom);
        end
        // The top data bit has no place in scale_factor and must be dropped.
        return {1'($urandom_range(0, 1)), scale_word};
    endfunction

    // Most thresholds sit within the span of typical averages for this
    // scale, so the send flag toggles often.
    function automatic cfg_data_t pick_threshold(cfg_data_t scale_data);
        logic [31:0] typical;
        typical = (32'd30000 * 32'(scale_data[SCALE_W-1:0])) >> FRAC_SHIFT;
        if (typical > 32'(DIST_MAX)) begin
            typical = 32'(DIST_MAX);
        end
        case ($urandom_range(0, 5))
            0:       return cfg_data_t'($urandom_range(0, 32'(DIST_MAX)));
            1:       return $urandom_range(0, 1) ? cfg_data_t'(DIST_MAX) : '0;
            default: return cfg_data_t'($urandom_range(0, typical));
        endcase
    endfunction

    task automatic send_random(int count);
        repeat (count) begin
            send_echo(pick_echo(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : result_sink
        int       stall;
        reading_t seen;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_output) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_output = 1'b0;
            end
            stall = idling_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            seen.raw_distance     = m_raw_distance;
            seen.raw_valid        = m_raw_valid;
            seen.average_distance = m_average_distance;
            seen.average_valid    = m_average_valid;
            seen.send_now         = m_send_now;
            tracker.check_reading(seen);
        end
    end

    initial begin : stimulus
        cfg_data_t scale_data;
        tracker = new;
        aresetn          <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_index        <= REG_SCALE_FACTOR;
        cfg_data         <= '0;
        s_valid          <= 1'b0;
        s_echo_time_us   <= ECHO_TIMEOUT;
        s_link_connected <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: timeouts on an empty ring, then the echo extremes,
        // saturation and a ring that wraps.
        send_echo(ECHO_TIMEOUT, 1'b1);
        send_echo(ECHO_TIMEOUT, 1'b0);
        send_echo(ECHO_MIN, 1'b1);
        send_echo(ECHO_TIMEOUT, 1'b1);
        send_echo(ECHO_MAX, 1'b1);
        send_echo(ECHO_RANGE_MAX, 1'b0);
        send_echo(ECHO_TOP_BIT, 1'b1);
        send_echo(15'd100, 1'b1);
        send_echo(15'd1747, 1'b1);
        send_echo(ECHO_TIMEOUT, 1'b1);
        send_echo(15'd5000, 1'b0);

        // Largest scale with a zero threshold: nothing may be sent.
        configure(cfg_data_t'(DIST_MAX), '0);
        send_echo(ECHO_MIN, 1'b1);
        send_echo(ECHO_MAX, 1'b1);
        send_echo(ECHO_TIMEOUT, 1'b1);

        // Zero scale with the largest threshold.
        configure('0, cfg_data_t'(DIST_MAX));
        send_echo(ECHO_RANGE_MAX, 1'b1);
        send_echo(ECHO_TIMEOUT, 1'b0);

        // Unit scale, so the mean lands exactly on the threshold and then
        // one below it.
        configure(17'h1_0100, 17'd8192);
        repeat (5) send_echo(15'd8192, 1'b1);
        repeat (5) send_echo(15'd8191, 1'b1);

        for (int phase = 0; phase < 10; phase++) begin
            scale_data = pick_scale();
            configure(scale_data, pick_threshold(scale_data));
            idling_on = (phase != 6);
            if (phase == 2) begin
                send_random(40);
                hold_output = 1'b1;
                send_random(110);
            end else if (phase == 5) begin
                send_random(75);
                wait_for_results();
                send_random(75);
            end else begin
                send_random(150);
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending_count() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
